FILE: hdl/http_rhp_pkg.sv
// Shared types, codes and constants of the HTTP request header parser.
`default_nettype none

package http_rhp_pkg;

    // Parse phase, one-hot
    typedef enum logic [7:0] {
        PH_METHOD     = 8'b0000_0001,
        PH_URI        = 8'b0000_0010,
        PH_VERSION    = 8'b0000_0100,
        PH_VERSION_LF = 8'b0000_1000,
        PH_LINE_START = 8'b0001_0000,
        PH_NAME       = 8'b0010_0000,
        PH_VALUE      = 8'b0100_0000,
        PH_SKIP       = 8'b1000_0000
    } phase_t;

    // Result kinds
    localparam logic [2:0] KIND_METHOD  = 3'd0;
    localparam logic [2:0] KIND_URI     = 3'd1;
    localparam logic [2:0] KIND_NAME    = 3'd2;
    localparam logic [2:0] KIND_VALUE   = 3'd3;
    localparam logic [2:0] KIND_COMMIT  = 3'd4;
    localparam logic [2:0] KIND_DISCARD = 3'd5;
    localparam logic [2:0] KIND_DONE    = 3'd6;
    localparam logic [2:0] KIND_ERROR   = 3'd7;

    // Error and method codes carried in the payload
    localparam logic [7:0] ERR_BAD_REQUEST = 8'd0;
    localparam logic [7:0] ERR_NOT_ALLOWED = 8'd1;
    localparam logic [7:0] METHOD_GET      = 8'd0;
    localparam logic [7:0] METHOD_POST     = 8'd1;
    localparam logic [7:0] METHOD_HEAD     = 8'd2;

    // Register indexes
    localparam logic CFG_NAME_LIMIT  = 1'b0;
    localparam logic CFG_VALUE_LIMIT = 1'b1;

    localparam logic [7:0]  NAME_LIMIT_RESET  = 8'd99;
    localparam logic [11:0] VALUE_LIMIT_RESET = 12'd999;

    // Characters
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Method words as shifted in
    localparam logic [31:0] WORD_GET  = 32'h0047_4554;
    localparam logic [31:0] WORD_POST = 32'h504F_5354;
    localparam logic [31:0] WORD_HEAD = 32'h4845_4144;

    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
    localparam int          MAX_RESULTS = 3;
    localparam int          QUEUE_DEPTH = 4;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] method_chars;
        logic [2:0]  method_length;
        logic [7:0]  pending_byte;
        logic        pending_valid;
        logic [7:0]  name_count;
        logic [11:0] value_count;
        logic [15:0] consumed_count;
        logic [1:0]  after_version_count;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:               PH_METHOD,
        method_chars:        32'd0,
        method_length:       3'd0,
        pending_byte:        8'd0,
        pending_valid:       1'b0,
        name_count:          8'd0,
        value_count:         12'd0,
        consumed_count:      16'd0,
        after_version_count: 2'd0
    };

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload;
        logic [15:0] byte_count;
        logic        complete;
        logic        last_of_run;
    } res_t;

    // Result group handed from the step logic to the queue
    typedef struct packed {
        res_t [MAX_RESULTS-1:0] items;
        logic [1:0]             n;
    } res_set_t;

endpackage

`default_nettype wire

FILE: hdl/http_rhp_step.sv
// Per-byte parse logic: next state and the result items of one input byte.
`default_nettype none

module http_rhp_step (
    input  wire http_rhp_pkg::state_t   st,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   end_of_buffer,
    input  wire logic [7:0]             name_limit,
    input  wire logic [11:0]            value_limit,
    output http_rhp_pkg::state_t        st_next,
    output http_rhp_pkg::res_set_t      results
);
    import http_rhp_pkg::*;

    typedef struct packed {
        state_t   st;
        res_set_t rs;
    } work_t;

    // Append one result item, at most three per byte
    function automatic work_t f_emit(work_t w, logic [2:0] kind, logic [7:0] pl,
                                     logic [15:0] cnt, logic cp);
        work_t r;
        r = w;
        if (r.rs.n != 2'd3) begin
            r.rs.items[r.rs.n] = '{kind: kind, payload: pl, byte_count: cnt,
                                   complete: cp, last_of_run: 1'b0};
            r.rs.n = r.rs.n + 2'd1;
        end
        return r;
    endfunction

    function automatic work_t f_fail(work_t w, logic [7:0] code);
        work_t r;
        r = f_emit(w, KIND_ERROR, code, 16'd0, 1'b0);
        r.st.phase = PH_SKIP;
        return r;
    endfunction

    // Ordinary header byte: pass on if under the field's limit
    function automatic work_t f_plain(work_t w, logic [7:0] b, logic [7:0] nl,
                                      logic [11:0] vl);
        work_t r;
        r = w;
        if (r.st.phase == PH_LINE_START)
            r.st.phase = PH_NAME;
        if (r.st.phase == PH_NAME) begin
            if (r.st.name_count < nl) begin
                r = f_emit(r, KIND_NAME, b, 16'd0, 1'b0);
                r.st.name_count = r.st.name_count + 8'd1;
            end
        end else if (r.st.phase == PH_VALUE) begin
            if (r.st.value_count < vl) begin
                r = f_emit(r, KIND_VALUE, b, 16'd0, 1'b0);
                r.st.value_count = r.st.value_count + 12'd1;
            end
        end
        return r;
    endfunction

    work_t w;
    logic  hdr_done;
    logic  pend_plain;

    always_comb begin
        w.st       = st;
        w.rs       = '0;
        hdr_done   = 1'b0;
        pend_plain = 1'b0;

        // byte counter runs until done or error
        if (w.st.phase != PH_SKIP && w.st.consumed_count != COUNT_MAX)
            w.st.consumed_count = w.st.consumed_count + 16'd1;

        case (st.phase)
            PH_METHOD: begin
                if (data_byte == CH_SP) begin
                    if (w.st.method_length == 3'd3 && w.st.method_chars == WORD_GET) begin
                        w = f_emit(w, KIND_METHOD, METHOD_GET, 16'd0, 1'b0);
                        w.st.phase = PH_URI;
                    end else if (w.st.method_length == 3'd4 &&
                                 w.st.method_chars == WORD_POST) begin
                        w = f_emit(w, KIND_METHOD, METHOD_POST, 16'd0, 1'b0);
                        w.st.phase = PH_URI;
                    end else if (w.st.method_length == 3'd4 &&
                                 w.st.method_chars == WORD_HEAD) begin
                        w = f_emit(w, KIND_METHOD, METHOD_HEAD, 16'd0, 1'b0);
                        w.st.phase = PH_URI;
                    end else begin
                        w = f_fail(w, ERR_NOT_ALLOWED);
                    end
                end else begin
                    if (w.st.method_length < 3'd4)
                        w.st.method_chars = {w.st.method_chars[23:0], data_byte};
                    if (w.st.method_length < 3'd5)
                        w.st.method_length = w.st.method_length + 3'd1;
                end
            end
            PH_URI: begin
                if (data_byte == CH_SP)
                    w.st.phase = PH_VERSION;
                else
                    w = f_emit(w, KIND_URI, data_byte, 16'd0, 1'b0);
            end
            PH_VERSION: begin
                if (data_byte == CH_CR)
                    w.st.phase = PH_VERSION_LF;
            end
            PH_VERSION_LF: begin
                if (data_byte == CH_LF) begin
                    w.st.phase = PH_LINE_START;
                    w.st.after_version_count = 2'd0;
                end else begin
                    w = f_fail(w, ERR_BAD_REQUEST);
                end
            end
            PH_LINE_START, PH_NAME, PH_VALUE: begin
                if (w.st.after_version_count != 2'd3)
                    w.st.after_version_count = w.st.after_version_count + 2'd1;
                if (!(end_of_buffer && w.st.after_version_count != 2'd3)) begin
                    // resolve the held CR or colon against this byte
                    if (w.st.pending_valid) begin
                        w.st.pending_valid = 1'b0;
                        if (w.st.pending_byte == CH_CR && data_byte == CH_LF) begin
                            hdr_done = 1'b1;
                            if (w.st.phase == PH_LINE_START) begin
                                w = f_emit(w, KIND_DONE, 8'd0, w.st.consumed_count, 1'b1);
                                w.st.phase = PH_SKIP;
                            end else begin
                                w = f_emit(w, (w.st.phase == PH_VALUE) ? KIND_COMMIT
                                                                     : KIND_DISCARD,
                                           8'd0, 16'd0, 1'b0);
                                w.st.phase       = PH_LINE_START;
                                w.st.name_count  = 8'd0;
                                w.st.value_count = 12'd0;
                            end
                        end else if (w.st.pending_byte == CH_COLON && data_byte == CH_SP &&
                                     w.st.phase != PH_VALUE) begin
                            hdr_done = 1'b1;
                            if (w.st.phase == PH_LINE_START)
                                w = f_fail(w, ERR_BAD_REQUEST);
                            else
                                w.st.phase = PH_VALUE;
                        end else begin
                            pend_plain = 1'b1;
                        end
                    end
                    if (pend_plain)
                        w = f_plain(w, w.st.pending_byte, name_limit, value_limit);
                    if (!hdr_done) begin
                        if (data_byte == CH_CR || data_byte == CH_COLON) begin
                            w.st.pending_byte  = data_byte;
                            w.st.pending_valid = 1'b1;
                        end else begin
                            w = f_plain(w, data_byte, name_limit, value_limit);
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // end of buffer: close the request and return to reset
        if (end_of_buffer) begin
            if (w.st.phase == PH_METHOD || w.st.phase == PH_URI ||
                w.st.phase == PH_VERSION || w.st.phase == PH_VERSION_LF) begin
                w = f_fail(w, ERR_BAD_REQUEST);
            end else if (w.st.phase != PH_SKIP) begin
                if (w.st.after_version_count != 2'd3) begin
                    w = f_fail(w, ERR_BAD_REQUEST);
                end else begin
                    if (w.st.pending_valid) begin
                        w.st.pending_valid = 1'b0;
                        w = f_plain(w, w.st.pending_byte, name_limit, value_limit);
                    end
                    w = f_emit(w, KIND_DONE, 8'd0, w.st.consumed_count, 1'b0);
                end
            end
            w.st = STATE_RESET;
        end

        // mark the final item of this byte
        if (w.rs.n != 2'd0)
            w.rs.items[w.rs.n - 2'd1].last_of_run = 1'b1;
    end

    assign st_next = w.st;
    assign results = w.rs;

endmodule

`default_nettype wire

FILE: hdl/http_rhp_outq.sv
// Result queue: takes up to three items at once, hands out one per handshake.
`default_nettype none

module http_rhp_outq (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push_en,
    input  wire http_rhp_pkg::res_set_t push_set,
    input  wire logic                   pop,
    output http_rhp_pkg::res_t          head,
    output logic                        head_valid,
    output logic [2:0]                  count
);
    import http_rhp_pkg::*;

    res_t [QUEUE_DEPTH-1:0] entries_reg;
    res_t [QUEUE_DEPTH-1:0] entries_next;
    logic [2:0]             count_reg;
    logic [2:0]             count_next;
    logic [2:0]             base;

    // shift out the head, then append the new group behind what is left
    always_comb begin
        entries_next = entries_reg;
        base         = count_reg;
        if (pop && count_reg != 3'd0) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                entries_next[i] = entries_reg[i+1];
            base = count_reg - 3'd1;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                if (push_en && 2'(k) < push_set.n && (base + 3'(k)) == 3'(i))
                    entries_next[i] = push_set.items[k];
            end
        end
        count_next = base + (push_en ? {1'b0, push_set.n} : 3'd0);
    end

    always_ff @(posedge aclk) begin
        entries_reg <= entries_next;
        if (!aresetn)
            count_reg <= 3'd0;
        else
            count_reg <= count_next;
    end

    assign head       = entries_reg[0];
    assign head_valid = (count_reg != 3'd0);
    assign count      = count_reg;

endmodule

`default_nettype wire

FILE: hdl/http_request_header_parser_core.sv
// HTTP request header parser, top level: input register, parse step, result queue.
// An accepted byte waits in the input register until the queue has room; its result
// items are then registered in the queue before the output port can take them.
// Throughput: one byte per cycle while each byte gives at most one result item and
// m_tready stays high; a byte's items leave in turn through the one-item output port.
// The input stage waits while more than one item is queued (queue depth four).
// Reset (aresetn low, synchronous) clears the parse state, queue and input stage
// and loads the limit registers with 99 and 999.
`default_nettype none

module http_request_header_parser_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_buffer
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] payload, [23:8] byte_count, [24] complete
    output logic [2:0]       m_tuser,   // [2:0] kind
    output logic             m_tlast,   // last_of_run
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [11:0] cfg_wdata
);
    import http_rhp_pkg::*;

    logic [7:0]  name_limit_reg;
    logic [11:0] value_limit_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eob_reg;

    state_t      state_reg;
    state_t      state_next;
    res_set_t    step_results;

    res_t        q_head;
    logic        q_valid;
    logic [2:0]  q_count;
    logic        proc;
    logic        s_accept;

    // the held item is parsed once the queue has room for three
    assign proc     = in_valid_reg && (q_count <= 3'd1);
    assign s_tready = !in_valid_reg || proc;
    assign s_accept = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_limit_reg  <= NAME_LIMIT_RESET;
            value_limit_reg <= VALUE_LIMIT_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_NAME_LIMIT)
                name_limit_reg <= cfg_wdata[7:0];
            if (cfg_index == CFG_VALUE_LIMIT)
                value_limit_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_eob_reg  <= s_tlast;
        end
        if (!aresetn)
            in_valid_reg <= 1'b0;
        else if (s_accept)
            in_valid_reg <= 1'b1;
        else if (proc)
            in_valid_reg <= 1'b0;
    end

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= STATE_RESET;
        else if (proc)
            state_reg <= state_next;
    end

    http_rhp_step u_step (
        .st            (state_reg),
        .data_byte     (in_byte_reg),
        .end_of_buffer (in_eob_reg),
        .name_limit    (name_limit_reg),
        .value_limit   (value_limit_reg),
        .st_next       (state_next),
        .results       (step_results)
    );

    http_rhp_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_en    (proc),
        .push_set   (step_results),
        .pop        (m_tready),
        .head       (q_head),
        .head_valid (q_valid),
        .count      (q_count)
    );

    assign m_tvalid = q_valid;
    assign m_tdata  = {7'd0, q_head.complete, q_head.byte_count, q_head.payload};
    assign m_tuser  = q_head.kind;
    assign m_tlast  = q_head.last_of_run;

endmodule

`default_nettype wire
